// ----- src/cfh_pkg.sv -----
// ----------------------------------------------------------------------------
// cfh_pkg: shared definitions for the compass heading unit
// Widths, CORDIC stage angles and the record types that travel along the
// vectoring pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cfh_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int SENSOR_W   = 16;
  localparam int FRAC_BITS  = 16;
  localparam int GUARD_BITS = 3;
  localparam int XW         = SENSOR_W + FRAC_BITS + GUARD_BITS;
  localparam int SHIFT_W    = 5;
  localparam int HEAD_W     = 16;

  localparam int Z_DOWN = (ANGLE_BITS >= HEAD_W) ? ANGLE_BITS - HEAD_W : 0;
  localparam int Z_UP   = (ANGLE_BITS >= HEAD_W) ? 0 : HEAD_W - ANGLE_BITS;

  localparam logic [HEAD_W-1:0] CENTI_SCALE = 16'd36000;
  localparam logic [HEAD_W-1:0] DECL_RESET  = 16'd243;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = {2'b01, {(ANGLE_BITS-2){1'b0}}};

  // atan(2^-i) in units of 2^32 per turn, rounded to nearest.
  localparam logic [31:0] ATAN_TURN32 [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [ANGLE_BITS-1:0] z;
  } cfh_vec_t;

  typedef struct packed {
    logic [HEAD_W-1:0] bin;
    logic [HEAD_W-1:0] centi;
  } cfh_head_t;

  // Stage angle scaled from 2^32 per turn to 2^ANGLE_BITS per turn,
  // rounding half up.
  function automatic logic [ANGLE_BITS-1:0] stage_angle(input int i);
    logic [32:0] t;
    int          sh;
    t  = {1'b0, ATAN_TURN32[i[4:0]]};
    sh = 32 - ANGLE_BITS;
    if (sh != 0) begin
      t = (t + (33'd1 << (sh - 1))) >> sh;
    end
    return t[ANGLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/cfh_if.sv -----
// ----------------------------------------------------------------------------
// cfh_if: request channels of the compass heading unit
// Sample channel (field readings in) and heading channel (results out).
// ----------------------------------------------------------------------------
`default_nettype none

interface cfh_sample_if import cfh_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SENSOR_W-1:0] sensor_x;
  logic signed [SENSOR_W-1:0] sensor_y;

  modport source (output valid, output sensor_x, output sensor_y, input ready);
  modport sink   (input valid, input sensor_x, input sensor_y, output ready);
endinterface

interface cfh_heading_if import cfh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HEAD_W-1:0] heading_binary_angle;
  logic [HEAD_W-1:0] heading_centidegrees;

  modport source (output valid, output heading_binary_angle,
                  output heading_centidegrees, input ready);
  modport sink   (input valid, input heading_binary_angle,
                  input heading_centidegrees, output ready);
endinterface

`default_nettype wire

// ----- src/compass_heading_from_field_unit.sv -----
// ----------------------------------------------------------------------------
// compass_heading_from_field_unit: CORDIC compass heading
// Computes atan2(Y, X) of a magnetometer sample, adds the declination and
// reports the heading in binary angle units and in centidegrees.
// ----------------------------------------------------------------------------
// Usage:
// Field samples arrive as requests on the sample channel (sensor_x and
// sensor_y, signed raw counts). Each request yields exactly one request on
// the heading channel, in order. The block holds no per-sample state.
// The declination is written through cfg_wr_en / cfg_wr_data while the
// block is idle, a rule on the user that the block does not enforce; reset
// loads 243 units (about 1.33 degrees). A heading passes one pre-rotation
// register, one register per CORDIC cell (16 cells), and the output
// register. The cell chain moves forward whenever the skid register is
// empty, so throughput is one sample per clock while the receiver keeps up.
// When the receiver stalls, the output register holds its result and one
// more finished result is caught in a skid register; only while the skid
// register is full does the chain freeze and sample.ready go low, and
// sample.ready is driven from a register.
// Reset (rst, synchronous) empties the chain and both output registers and
// restores the declination.
// ----------------------------------------------------------------------------
`default_nettype none

module compass_heading_from_field_unit import cfh_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  cfh_sample_if.sink           sample,
  cfh_heading_if.source        heading,
  input  wire logic            cfg_wr_en,
  input  wire logic [HEAD_W-1:0] cfg_wr_data
);

  logic [HEAD_W-1:0]      declination;
  logic                   adv;
  logic [CORDIC_STAGES:0] stage_valid;
  cfh_vec_t               stage_vec [CORDIC_STAGES+1];
  cfh_head_t              fin_head;
  cfh_head_t              out_head;
  cfh_head_t              skid_head;
  logic                   out_valid;
  logic                   skid_valid;
  logic                   out_fire;

  // Declination register.
  always_ff @(posedge clk) begin
    if (rst) begin
      declination <= DECL_RESET;
    end else if (cfg_wr_en) begin
      declination <= cfg_wr_data;
    end
  end

  // The whole chain moves forward unless a stalled result sits in the skid
  // register.
  assign adv          = !skid_valid;
  assign sample.ready = adv;

  cfh_prerot u_prerot (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sample.valid),
    .sensor_x  (sample.sensor_x),
    .sensor_y  (sample.sensor_y),
    .out_valid (stage_valid[0]),
    .out_vec   (stage_vec[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    cfh_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (stage_valid[k]),
      .in_vec    (stage_vec[k]),
      .shift     (SHIFT_W'(k)),
      .angle     (stage_angle(k)),
      .out_valid (stage_valid[k+1]),
      .out_vec   (stage_vec[k+1])
    );
  end

  cfh_finish u_finish (
    .z           (stage_vec[CORDIC_STAGES].z),
    .declination (declination),
    .head        (fin_head)
  );

  // Output register with a one-entry skid register behind it.
  assign out_fire = out_valid && heading.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (adv && stage_valid[CORDIC_STAGES]) begin
        if (!out_valid || out_fire) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (skid_valid && out_fire) begin
        skid_valid <= 1'b0;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end else begin
        out_valid  <= out_valid;
        skid_valid <= skid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (adv && stage_valid[CORDIC_STAGES]) begin
      if (!out_valid || out_fire) begin
        out_head <= fin_head;
      end else begin
        skid_head <= fin_head;
      end
    end else if (skid_valid && out_fire) begin
      out_head <= skid_head;
    end else begin
      out_head <= out_head;
    end
  end

  assign heading.valid                = out_valid;
  assign heading.heading_binary_angle = out_head.bin;
  assign heading.heading_centidegrees = out_head.centi;

  // A result waiting in the skid register implies the output register is full.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // Draining the skid register moves its result to the output unchanged.
  a_skid_drain : assert property (@(posedge clk) disable iff (rst)
    (skid_valid && heading.ready) |=>
      (out_valid && !skid_valid && out_head == $past(skid_head)))
    else $error("skid result not moved to output");

  // The centidegree value stays inside one turn.
  a_centi_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_head.centi < 16'd36000))
    else $error("centidegree heading out of range");

endmodule

`default_nettype wire

// ----- src/cfh_prerot.sv -----
// ----------------------------------------------------------------------------
// cfh_prerot: quadrant pre-rotation
// Scales the raw sample to fixed point and turns vectors in the left half
// plane by a quarter turn so the CORDIC cells see x >= 0.
// ----------------------------------------------------------------------------
`default_nettype none

module cfh_prerot import cfh_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic                       in_valid,
  input  wire logic signed [SENSOR_W-1:0] sensor_x,
  input  wire logic signed [SENSOR_W-1:0] sensor_y,
  output      logic                       out_valid,
  output      cfh_vec_t                   out_vec
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  cfh_vec_t             vec_next;

  always_comb begin
    xs = XW'(sensor_x) <<< FRAC_BITS;
    ys = XW'(sensor_y) <<< FRAC_BITS;
    vec_next.x = xs;
    vec_next.y = ys;
    vec_next.z = '0;
    if (sensor_x < 0) begin
      if (sensor_y >= 0) begin
        vec_next.x = ys;
        vec_next.y = -xs;
        vec_next.z = QUARTER_TURN;
      end else begin
        vec_next.x = -ys;
        vec_next.y = xs;
        vec_next.z = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_vec <= vec_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/cfh_cell.sv -----
// ----------------------------------------------------------------------------
// cfh_cell: one CORDIC vectoring cell
// Rotates the vector toward the X axis by the stage angle and accumulates
// the angle; a vector already on the axis passes unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module cfh_cell import cfh_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire cfh_vec_t              in_vec,
  input  wire logic [SHIFT_W-1:0]    shift,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output      logic                  out_valid,
  output      cfh_vec_t              out_vec
);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  cfh_vec_t             vec_next;

  always_comb begin
    dx       = in_vec.y >>> shift;
    dy       = in_vec.x >>> shift;
    vec_next = in_vec;
    if (in_vec.y > 0) begin
      vec_next.x = in_vec.x + dx;
      vec_next.y = in_vec.y - dy;
      vec_next.z = in_vec.z + angle;
    end else if (in_vec.y < 0) begin
      vec_next.x = in_vec.x - dx;
      vec_next.y = in_vec.y + dy;
      vec_next.z = in_vec.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_vec <= vec_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/cfh_finish.sv -----
// ----------------------------------------------------------------------------
// cfh_finish: heading formatting
// Brings the CORDIC angle to 16-bit binary angle units, adds the declination
// and converts the heading to hundredths of a degree.
// ----------------------------------------------------------------------------
`default_nettype none

module cfh_finish import cfh_pkg::*; (
  input  wire logic [ANGLE_BITS-1:0] z,
  input  wire logic [HEAD_W-1:0]     declination,
  output      cfh_head_t             head
);

  logic [31:0]         z_wide;
  logic [HEAD_W-1:0]   z_head;
  logic [2*HEAD_W-1:0] prod;

  always_comb begin
    z_wide     = 32'(z);
    z_head     = HEAD_W'((z_wide >> Z_DOWN) << Z_UP);
    head.bin   = z_head + declination;
    prod       = (2*HEAD_W)'(head.bin) * (2*HEAD_W)'(CENTI_SCALE);
    head.centi = prod[2*HEAD_W-1 -: HEAD_W];
  end

endmodule

`default_nettype wire

// ----- dv/heading_checker.sv -----
// ----------------------------------------------------------------------------
// heading_checker: scoreboard for the compass heading unit
// Watches the sample and heading channels and the declination write port,
// predicts each heading from the accepted field sample and compares the
// results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heading_checker import cfh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [HEAD_W-1:0] cfg_wr_data,
  cfh_sample_if             sample,
  cfh_heading_if            heading,
  output int                fail_count,
  output int                outstanding
);

  localparam int REPORT_CAP = 100;

  cfh_head_t         heading_due [$];
  logic [HEAD_W-1:0] decl_shadow;
  int                errors;
  int                reported;

  // Vectoring CORDIC on 64-bit integers; >>> on a signed value rounds toward
  // minus infinity, which is the arithmetic shift of the hardware.
  function automatic cfh_head_t heading_of_field(input logic signed [SENSOR_W-1:0] sx,
                                                 input logic signed [SENSOR_W-1:0] sy,
                                                 input logic [HEAD_W-1:0] decl);
    longint            x, y, z, t, dx, dy, a;
    longint unsigned   zu, amask;
    logic [HEAD_W-1:0] h;
    logic [31:0]       prod;
    cfh_head_t         r;
    x = longint'(sx) * 65536;
    y = longint'(sy) * 65536;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = longint'(1) << (ANGLE_BITS - 2);
      end else begin
        x = -y;
        y = t;
        z = -(longint'(1) << (ANGLE_BITS - 2));
      end
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      a = longint'(ATAN_TURN32[i[4:0]]);
      if (ANGLE_BITS < 32) begin
        a = (a + (longint'(1) << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
      end
      dx = y >>> (i & 31);
      dy = x >>> (i & 31);
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + a;
      end else if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - a;
      end
    end
    amask = (64'd1 << ANGLE_BITS) - 64'd1;
    zu    = longint'(z) & amask;
    if (ANGLE_BITS >= HEAD_W) begin
      h = HEAD_W'(zu >> Z_DOWN);
    end else begin
      h = HEAD_W'(zu << Z_UP);
    end
    h       = h + decl;
    prod    = 32'(h) * 32'd36000;
    r.bin   = h;
    r.centi = prod[31:16];
    return r;
  endfunction

  initial begin
    errors      = 0;
    reported    = 0;
    decl_shadow = DECL_RESET;
  end

  always @(posedge clk) begin
    cfh_head_t due;
    cfh_head_t got;
    if (rst) begin
      heading_due.delete();
      decl_shadow = DECL_RESET;
    end else begin
      if (cfg_wr_en) begin
        decl_shadow = cfg_wr_data;
      end
      if (sample.valid && sample.ready) begin
        heading_due.push_back(heading_of_field(sample.sensor_x, sample.sensor_y,
                                               decl_shadow));
      end
      if (heading.valid && heading.ready) begin
        got.bin   = heading.heading_binary_angle;
        got.centi = heading.heading_centidegrees;
        if (heading_due.size() == 0) begin
          errors++;
          if (reported < REPORT_CAP) begin
            $display("%0t: unexpected heading, expected none, actual bin=%0d centi=%0d",
                     $time, got.bin, got.centi);
            reported++;
          end
        end else begin
          due = heading_due.pop_front();
          if (got.bin !== due.bin || got.centi !== due.centi) begin
            errors++;
            if (reported < REPORT_CAP) begin
              $display("%0t: heading mismatch, expected bin=%0d centi=%0d, actual bin=%0d centi=%0d",
                       $time, due.bin, due.centi, got.bin, got.centi);
              reported++;
            end
          end
        end
      end
    end
    fail_count  <= errors;
    outstanding <= heading_due.size();
  end

endmodule

// ----- dv/tb_compass_heading_from_field_unit.sv -----
// ----------------------------------------------------------------------------
// tb_compass_heading_from_field_unit: regression for the compass heading unit
// Drives directed and random magnetometer samples under several declination
// settings, stalls the heading receiver at random and once for a long
// stretch, and leaves prediction and comparison to the checker beside the
// block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_compass_heading_from_field_unit;
  import cfh_pkg::*;

  // Cycles with no accepted request on either channel before the run is
  // declared hung. The longest quiet stretch in a correct run is the long
  // receiver hold plus a drain.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settling time once every expected heading has come back.
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 150;
  localparam int PHASE_ITEMS    = 175;
  localparam int NUM_PHASES     = 6;
  localparam int NUM_DIRECTED   = 22;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [HEAD_W-1:0] cfg_wr_data;
  int                fail_count;
  int                outstanding;
  int                idle_cycles;

  // Handshake between the sender and the receiver for the long hold.
  bit                hold_req;

  cfh_sample_if  sample_ch ();
  cfh_heading_if heading_ch ();

  compass_heading_from_field_unit uut (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .heading     (heading_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  heading_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (sample_ch),
    .heading     (heading_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Directed samples: the four axis extremes, all four corners, the zero
  // field, unit vectors around the origin, and the positive X axis on which
  // every CORDIC stage holds.
  int dir_x [NUM_DIRECTED] = '{ 32767, -32768,      0,      0,      0, -32768,
                                32767, -32768,  32767,     -1,     -1,      0,
                                    1,      1,     -1,      1, -32768,     -1,
                                  100,      0,  32767, -32768 };
  int dir_y [NUM_DIRECTED] = '{     0,      0,  32767, -32768,      0, -32768,
                                32767,  32767, -32768,      0,     -1,     -1,
                                    0,     -1,      1,      1,     -1, -32768,
                                    0,      1,      1,     -1 };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length shared by both sides: usually none or a short one, now and
  // then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Random field sample. Most are full-range readings; the rest aim at the
  // corners of the behavior: tiny vectors, the axes, the extremes and the
  // diagonals where the pre-rotation and the first stage meet.
  function automatic void make_field(output logic signed [SENSOR_W-1:0] fx,
                                     output logic signed [SENSOR_W-1:0] fy);
    logic signed [SENSOR_W-1:0] v;
    int                         kind;
    kind = $urandom_range(0, 9);
    fx   = SENSOR_W'($urandom);
    fy   = SENSOR_W'($urandom);
    case (kind)
      5: begin
        fx = SENSOR_W'($urandom_range(0, 15)) - 16'sd8;
        fy = SENSOR_W'($urandom_range(0, 15)) - 16'sd8;
      end
      6: begin
        if ($urandom_range(0, 1) == 0) begin
          fy = '0;
        end else begin
          fx = '0;
        end
      end
      7: begin
        case ($urandom_range(0, 4))
          0: fx = -16'sd32768;
          1: fx = -16'sd1;
          2: fx = 16'sd0;
          3: fx = 16'sd1;
          default: fx = 16'sd32767;
        endcase
        case ($urandom_range(0, 4))
          0: fy = -16'sd32768;
          1: fy = -16'sd1;
          2: fy = 16'sd0;
          3: fy = 16'sd1;
          default: fy = 16'sd32767;
        endcase
      end
      8: begin
        v  = SENSOR_W'($urandom_range(0, 32767));
        fx = ($urandom_range(0, 1) == 0) ? v : -v;
        fy = ($urandom_range(0, 1) == 0) ? v : -v;
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one sample request and returns at the edge that accepts it, with
  // valid still high so that a following request can go out back to back.
  task automatic push_sample(input logic signed [SENSOR_W-1:0] fx,
                             input logic signed [SENSOR_W-1:0] fy);
    sample_ch.valid    <= 1'b1;
    sample_ch.sensor_x <= fx;
    sample_ch.sensor_y <= fy;
    do begin
      @(posedge clk);
    end while (!sample_ch.ready);
  endtask

  // Sends one sample and then idles for a random gap unless the caller asks
  // for a back-to-back stream.
  task automatic send_with_gap(input logic signed [SENSOR_W-1:0] fx,
                               input logic signed [SENSOR_W-1:0] fy,
                               input bit no_idle);
    int g;
    push_sample(fx, fy);
    g = no_idle ? 0 : gap_len();
    if (g > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Lowers valid and waits until every expected heading has come back, then
  // lets the pipeline settle. The checker's count is registered, so the task
  // waits for the next clock edge before it trusts the count.
  task automatic drain_pipeline();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The declination register is written only with the pipeline empty.
  task automatic write_declination(input logic [HEAD_W-1:0] value);
    drain_pipeline();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Heading receiver: ready runs high for random stretches with random gaps
  // between them. When the sender asks for it, ready is held low for a long
  // stretch so that the pipeline and skid register fill and the block has to
  // push back on sample requests.
  initial begin
    int n;
    heading_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        heading_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = $urandom_range(1, 40);
      repeat (n) begin
        heading_ch.ready <= 1'b1;
        @(posedge clk);
      end
      n = gap_len();
      if (n > 0) begin
        heading_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Watchdog: a run that stops accepting requests on both channels for too
  // long is hung.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) ||
          (heading_ch.valid && heading_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic signed [SENSOR_W-1:0] fx;
    logic signed [SENSOR_W-1:0] fy;
    logic [HEAD_W-1:0]          decl_plan [NUM_PHASES];
    bit                         no_idle;

    hold_req           = 1'b0;
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    sample_ch.valid    <= 1'b0;
    sample_ch.sensor_x <= '0;
    sample_ch.sensor_y <= '0;

    // Both extremes of the register read as signed, zero, minus one and two random
    // settings follow the reset value.
    decl_plan[0] = 16'h7FFF;
    decl_plan[1] = 16'h8000;
    decl_plan[2] = 16'h0000;
    decl_plan[3] = 16'hFFFF;
    decl_plan[4] = HEAD_W'($urandom);
    decl_plan[5] = HEAD_W'($urandom);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples run under the declination that reset leaves behind.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_with_gap(SENSOR_W'(dir_x[i]), SENSOR_W'(dir_y[i]), 1'b0);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_declination(decl_plan[p]);
      @(posedge clk);
      // A zero field at the head of each phase reads back the declination.
      send_with_gap('0, '0, 1'b0);
      // One phase in four streams with no idling on the sample side.
      no_idle = ($urandom_range(0, 3) == 0);
      if (p == 2) begin
        // Long receiver hold while samples keep coming back to back.
        hold_req = 1'b1;
        no_idle  = 1'b1;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        make_field(fx, fy);
        send_with_gap(fx, fy, no_idle);
      end
    end

    drain_pipeline();
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
